FILE: hdl/swqm_pkg.sv
// Shared types and constants for the strided window quality mean block.
package swqm_pkg;

  localparam int QUAL_W       = 7;
  localparam int WSIZE_W      = 9;
  localparam int WSTEP_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int SUM_W        = 15;
  localparam int FRAC_W       = 8;
  localparam int DQ_W         = SUM_W + FRAC_W;
  localparam int DIV_CNT_W    = $clog2(DQ_W);
  localparam int READ_IDX_W   = 32;
  localparam int START_W      = 16;
  localparam int MEAN_W       = 15;

  localparam int MAX_WINDOW_DEF   = 256;
  localparam int MAX_READ_LEN_DEF = 65536;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 9'd10;
  localparam logic [WSTEP_W-1:0] WSTEP_RESET = 16'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/swqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/strided_window_quality_mean_core.sv
// Strided sliding-window mean of read quality scores: a base that yields no
// window passes through accept, then ring RAM read-modify-write; a base that
// completes a window on the stride goes through accept, ring update, 23
// iterations of the one-bit-per-cycle restoring divider and output load, where
// it waits while the output register is held by out_stall. The ring of
// recent scores lives in a RAM with registered read data; its contents are
// never used before being written in the current read, so it needs no clearing.
module strided_window_quality_mean_core #(
  parameter int MAX_WINDOW   = swqm_pkg::MAX_WINDOW_DEF,
  parameter int MAX_READ_LEN = swqm_pkg::MAX_READ_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [swqm_pkg::QUAL_W-1:0]         in_quality,
  input  logic                                in_read_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swqm_pkg::READ_IDX_W-1:0]     out_read_index,
  output logic [swqm_pkg::START_W-1:0]        out_window_start,
  output logic [swqm_pkg::MEAN_W-1:0]         out_mean_q8,
  input  logic                                cfg_we,
  input  logic [swqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swqm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW = $clog2(MAX_READ_LEN + 1);

  swqm_pkg::state_t state_r, state_nxt;

  logic [swqm_pkg::WSIZE_W-1:0]    wsize_r, wsize_nxt;
  logic [swqm_pkg::WSTEP_W-1:0]    wstep_r, wstep_nxt;
  logic [swqm_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [swqm_pkg::WSTEP_W-1:0]    phase_r, phase_nxt;
  logic [swqm_pkg::READ_IDX_W-1:0] rcnt_r, rcnt_nxt;
  logic [AW-1:0]                   wptr_r, wptr_nxt;

  logic [swqm_pkg::QUAL_W-1:0]     q_r, q_nxt;
  logic                            last_r, last_nxt;
  logic                            active_r, active_nxt;

  logic [swqm_pkg::DQ_W-1:0]       dq_r, dq_nxt;
  logic [swqm_pkg::WSIZE_W-1:0]    rem_r, rem_nxt;
  logic [swqm_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [swqm_pkg::READ_IDX_W-1:0] idx_r, idx_nxt;
  logic [swqm_pkg::START_W-1:0]    start_r, start_nxt;

  logic                            ovalid_r, ovalid_nxt;
  logic [swqm_pkg::READ_IDX_W-1:0] oidx_r, oidx_nxt;
  logic [swqm_pkg::START_W-1:0]    ostart_r, ostart_nxt;
  logic [swqm_pkg::MEAN_W-1:0]     omean_r, omean_nxt;

  logic [swqm_pkg::WSIZE_W-1:0]    w_eff;
  logic [swqm_pkg::WSTEP_W-1:0]    step_eff;
  logic [31:0]                     raddr_full;
  logic [AW-1:0]                   ring_raddr;
  logic [swqm_pkg::QUAL_W-1:0]     ring_rdata;
  logic                            ring_we;
  logic                            in_fire;
  logic [swqm_pkg::SUM_W-1:0]      old_q;
  logic [swqm_pkg::SUM_W-1:0]      sum_new;
  logic [31:0]                     start_full;
  logic [swqm_pkg::WSTEP_W:0]      phase_inc;
  logic [swqm_pkg::WSIZE_W:0]      trial;

  always_comb begin
    if (wsize_r == '0) begin
      w_eff = swqm_pkg::WSIZE_W'(1);
    end else if (32'(wsize_r) > 32'(MAX_WINDOW)) begin
      w_eff = swqm_pkg::WSIZE_W'(MAX_WINDOW);
    end else begin
      w_eff = wsize_r;
    end
    step_eff = (wstep_r == '0) ? swqm_pkg::WSTEP_W'(1) : wstep_r;
  end

  // Ring slot of position (pos - w), kept modulo MAX_WINDOW.
  always_comb begin
    if (32'(wptr_r) >= 32'(w_eff)) begin
      raddr_full = 32'(wptr_r) - 32'(w_eff);
    end else begin
      raddr_full = 32'(wptr_r) + 32'(MAX_WINDOW) - 32'(w_eff);
    end
    ring_raddr = raddr_full[AW-1:0];
  end

  swqm_ram #(
    .WIDTH (swqm_pkg::QUAL_W),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wptr_r),
    .wdata (q_r),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign in_stall = (state_r != swqm_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    wsize_nxt  = wsize_r;
    wstep_nxt  = wstep_r;
    sum_nxt    = sum_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    rcnt_nxt   = rcnt_r;
    wptr_nxt   = wptr_r;
    q_nxt      = q_r;
    last_nxt   = last_r;
    active_nxt = active_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    start_nxt  = start_r;
    ovalid_nxt = ovalid_r && out_stall;
    oidx_nxt   = oidx_r;
    ostart_nxt = ostart_r;
    omean_nxt  = omean_r;
    ring_we    = 1'b0;
    old_q      = (32'(pos_r) >= 32'(w_eff)) ? {{(swqm_pkg::SUM_W-swqm_pkg::QUAL_W){1'b0}},
                                               ring_rdata} : '0;
    sum_new    = sum_r - old_q + {{(swqm_pkg::SUM_W-swqm_pkg::QUAL_W){1'b0}}, q_r};
    start_full = 32'(pos_r) + 32'd1 - 32'(w_eff);
    phase_inc  = {1'b0, phase_r} + 1'b1;
    trial      = {rem_r, dq_r[swqm_pkg::DQ_W-1]};

    if (cfg_we) begin
      case (cfg_index)
        swqm_pkg::CFG_WINDOW_SIZE: begin
          wsize_nxt = cfg_wdata[swqm_pkg::WSIZE_W-1:0];
          sum_nxt   = '0;
          pos_nxt   = '0;
          phase_nxt = '0;
          wptr_nxt  = '0;
        end
        swqm_pkg::CFG_WINDOW_STEP: begin
          wstep_nxt = cfg_wdata[swqm_pkg::WSTEP_W-1:0];
        end
        default: ;
      endcase
    end

    case (state_r)
      swqm_pkg::ST_IDLE: begin
        if (in_fire) begin
          q_nxt      = in_quality;
          last_nxt   = in_read_end;
          active_nxt = 32'(pos_r) < 32'(MAX_READ_LEN);
          state_nxt  = swqm_pkg::ST_UPDATE;
        end
      end
      swqm_pkg::ST_UPDATE: begin
        state_nxt = swqm_pkg::ST_IDLE;
        if (active_r) begin
          ring_we  = 1'b1;
          sum_nxt  = sum_new;
          pos_nxt  = pos_r + 1'b1;
          wptr_nxt = (32'(wptr_r) == 32'(MAX_WINDOW - 1)) ? '0 : wptr_r + 1'b1;
          if (32'(pos_r) + 32'd1 >= 32'(w_eff)) begin
            if (phase_r == '0) begin
              dq_nxt    = {sum_new, {swqm_pkg::FRAC_W{1'b0}}};
              rem_nxt   = '0;
              cnt_nxt   = '0;
              idx_nxt   = rcnt_r;
              start_nxt = start_full[swqm_pkg::START_W-1:0];
              state_nxt = swqm_pkg::ST_DIV;
            end
            phase_nxt = (phase_inc >= {1'b0, step_eff}) ? '0 :
                        phase_inc[swqm_pkg::WSTEP_W-1:0];
          end
        end
        if (last_r) begin
          rcnt_nxt  = rcnt_r + 1'b1;
          sum_nxt   = '0;
          pos_nxt   = '0;
          phase_nxt = '0;
          wptr_nxt  = '0;
        end
      end
      swqm_pkg::ST_DIV: begin
        if (trial >= {1'b0, w_eff}) begin
          rem_nxt = swqm_pkg::WSIZE_W'(trial - {1'b0, w_eff});
          dq_nxt  = {dq_r[swqm_pkg::DQ_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[swqm_pkg::WSIZE_W-1:0];
          dq_nxt  = {dq_r[swqm_pkg::DQ_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == swqm_pkg::DQ_W - 1) begin
          state_nxt = swqm_pkg::ST_OUT;
        end
      end
      swqm_pkg::ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          oidx_nxt   = idx_r;
          ostart_nxt = start_r;
          omean_nxt  = dq_r[swqm_pkg::MEAN_W-1:0];
          state_nxt  = swqm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swqm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swqm_pkg::ST_IDLE;
      wsize_r  <= swqm_pkg::WSIZE_RESET;
      wstep_r  <= swqm_pkg::WSTEP_RESET;
      sum_r    <= '0;
      pos_r    <= '0;
      phase_r  <= '0;
      rcnt_r   <= '0;
      wptr_r   <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wsize_r  <= wsize_nxt;
      wstep_r  <= wstep_nxt;
      sum_r    <= sum_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      rcnt_r   <= rcnt_nxt;
      wptr_r   <= wptr_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    last_r   <= last_nxt;
    active_r <= active_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    idx_r    <= idx_nxt;
    start_r  <= start_nxt;
    oidx_r   <= oidx_nxt;
    ostart_r <= ostart_nxt;
    omean_r  <= omean_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_read_index   = oidx_r;
  assign out_window_start = ostart_r;
  assign out_mean_q8      = omean_r;

endmodule

FILE: test/strided_window_quality_mean_core_test.sv
// Self-checking testbench for strided_window_quality_mean_core: window predictor and scoreboard.
module strided_window_quality_mean_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 4;
  localparam int LIMIT_CYCLES  = 400_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [swqm_pkg::READ_IDX_W-1:0] read_index;
    logic [swqm_pkg::START_W-1:0]    window_start;
    logic [swqm_pkg::MEAN_W-1:0]     mean_q8;
  } window_t;

  typedef struct packed {
    logic [swqm_pkg::QUAL_W-1:0] quality;
    logic                        read_end;
    logic                        typed;
    logic                        emits;
    window_t                     want;
  } row_t;

  typedef struct packed {
    logic                         set_size;
    logic [swqm_pkg::WSIZE_W-1:0] size;
    logic                         set_step;
    logic [swqm_pkg::WSTEP_W-1:0] step;
    logic [15:0]                  items;
    logic                         idle;
  } setting_t;

  localparam window_t NO_WIN = '0;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [swqm_pkg::QUAL_W-1:0]     in_quality;
  logic                            in_read_end;
  logic                            out_valid;
  logic                            out_stall;
  logic [swqm_pkg::READ_IDX_W-1:0] out_read_index;
  logic [swqm_pkg::START_W-1:0]    out_window_start;
  logic [swqm_pkg::MEAN_W-1:0]     out_mean_q8;
  logic                            cfg_we;
  logic [swqm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swqm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // window tracker state
  logic [swqm_pkg::QUAL_W-1:0]     track_ring [swqm_pkg::MAX_WINDOW_DEF];
  logic [swqm_pkg::SUM_W-1:0]      track_sum   = '0;
  logic [16:0]                     track_pos   = '0;
  logic [swqm_pkg::WSTEP_W-1:0]    track_phase = '0;
  logic [swqm_pkg::READ_IDX_W-1:0] track_reads = '0;
  logic [swqm_pkg::WSIZE_W-1:0]    size_reg    = swqm_pkg::WSIZE_RESET;
  logic [swqm_pkg::WSTEP_W-1:0]    step_reg    = swqm_pkg::WSTEP_RESET;

  window_t     pending_windows [$];
  int unsigned cycle_count      = 0;
  int unsigned mismatches       = 0;
  int unsigned windows_checked  = 0;
  int unsigned bases_sent       = 0;
  int unsigned settings_applied = 0;
  int unsigned bases_left       = 0;
  bit          idle_on          = 1'b1;
  bit          hold_pending     = 1'b0;

  // after reset: size 10, step 5
  row_t directed_rows [25] = '{
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd93,  1'b1, 1'b1, 1'b1, '{32'd0, 16'd0, 15'd23808}},
    '{7'd127, 1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd127, 1'b1, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b1, 1'b0, NO_WIN},
    '{7'd0,   1'b1, 1'b1, 1'b1, '{32'd2, 16'd0, 15'd0}},
    '{7'd127, 1'b0, 1'b0, 1'b0, NO_WIN},
    '{7'd0,   1'b0, 1'b0, 1'b0, NO_WIN},
    '{7'd64,  1'b0, 1'b0, 1'b0, NO_WIN}
  };

  setting_t phase_plan [6] = '{
    '{1'b0, 9'd0,   1'b0, 16'd0,     16'd150, 1'b1},
    '{1'b1, 9'd0,   1'b1, 16'd0,     16'd120, 1'b1},
    '{1'b1, 9'd1,   1'b1, 16'hFFFF,  16'd100, 1'b0},
    '{1'b0, 9'd0,   1'b1, 16'd2,     16'd80,  1'b1},
    '{1'b1, 9'd511, 1'b1, 16'd3,     16'd300, 1'b1},
    '{1'b1, 9'd256, 1'b1, 16'd1,     16'd300, 1'b1}
  };

  strided_window_quality_mean_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_quality       (in_quality),
    .in_read_end      (in_read_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_index   (out_read_index),
    .out_window_start (out_window_start),
    .out_mean_q8      (out_mean_q8),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_window();
    if (size_reg == 0) return 1;
    if (size_reg > swqm_pkg::MAX_WINDOW_DEF) return swqm_pkg::MAX_WINDOW_DEF;
    return size_reg;
  endfunction

  function automatic void restart_tracking();
    track_sum   = '0;
    track_pos   = '0;
    track_phase = '0;
  endfunction

  function automatic bit advance_window(input logic [swqm_pkg::QUAL_W-1:0] q, input logic last,
                                        output window_t res);
    int unsigned w;
    int unsigned stp;
    int unsigned p;
    int unsigned start;
    bit          hit;
    hit = 1'b0;
    res = '0;
    w   = eff_window();
    stp = (step_reg == 0) ? 1 : step_reg;
    if (track_pos < swqm_pkg::MAX_READ_LEN_DEF) begin
      p = track_pos;
      if (p >= w) track_sum = track_sum - track_ring[(p - w) % swqm_pkg::MAX_WINDOW_DEF];
      track_sum = track_sum + q;
      track_ring[p % swqm_pkg::MAX_WINDOW_DEF] = q;
      track_pos = 17'(p + 1);
      if (p + 1 >= w) begin
        start = p + 1 - w;
        if (track_phase == 0) begin
          res.read_index   = track_reads;
          res.window_start = start[swqm_pkg::START_W-1:0];
          res.mean_q8      = swqm_pkg::MEAN_W'((int'(track_sum) << swqm_pkg::FRAC_W) / w);
          hit = 1'b1;
        end
        track_phase = (int'(track_phase) + 1 >= stp) ? '0 : track_phase + 1'b1;
      end
    end
    if (last) begin
      track_reads = track_reads + 1'b1;
      restart_tracking();
    end
    return hit;
  endfunction

  function automatic int unsigned draw_read_length();
    int unsigned w;
    int unsigned span;
    w    = eff_window();
    span = (step_reg == 0) ? 4 : 4 * int'(step_reg);
    if (span > 48) span = 48;
    if (w <= 32 && $urandom_range(0, 7) == 0) return $urandom_range(1, w);
    return w + $urandom_range(0, span);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycle_count, got, want);
    mismatches++;
  endtask

  task automatic send_base(input logic [swqm_pkg::QUAL_W-1:0] q, input logic last,
                           output bit hit, output window_t res);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_quality  <= q;
    in_read_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = advance_window(q, last, res);
    bases_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [swqm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [swqm_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == swqm_pkg::CFG_WINDOW_SIZE) begin
      size_reg   = value[swqm_pkg::WSIZE_W-1:0];
      bases_left = 0;
      restart_tracking();
    end else begin
      step_reg = value[swqm_pkg::WSTEP_W-1:0];
    end
  endtask

  task automatic apply_setting(input setting_t s);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (s.set_size) write_register(swqm_pkg::CFG_WINDOW_SIZE, swqm_pkg::CFG_DATA_W'(s.size));
    if (s.set_step) write_register(swqm_pkg::CFG_WINDOW_STEP, s.step);
    cfg_we  <= 1'b0;
    idle_on = s.idle;
    settings_applied++;
  endtask

  task automatic run_reads(input int items, input bit drain_midway, input bit hold_midway);
    bit      hit;
    window_t res;
    for (int i = 0; i < items; i++) begin
      if (drain_midway && i == items / 2) wait_drained();
      if (hold_midway && i == 8) hold_pending = 1'b1;
      if (bases_left == 0) bases_left = draw_read_length();
      bases_left--;
      send_base(swqm_pkg::QUAL_W'($urandom_range(0, 127)), bases_left == 0, hit, res);
      if (hit) pending_windows.push_back(res);
    end
  endtask

  // result side
  initial begin
    window_t     got;
    window_t     want;
    int unsigned hold_n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
        hold_n = 0;
      end else begin
        hold_n = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_n != 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (hold_n - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_read_index, out_window_start, out_mean_q8};
      if (pending_windows.size() == 0) begin
        report_mismatch("window with none pending", got.window_start, 0);
      end else begin
        want = pending_windows.pop_front();
        windows_checked++;
        if (got.read_index !== want.read_index)
          report_mismatch("read_index", got.read_index, want.read_index);
        if (got.window_start !== want.window_start)
          report_mismatch("window_start", got.window_start, want.window_start);
        if (got.mean_q8 !== want.mean_q8)
          report_mismatch("mean_q8", got.mean_q8, want.mean_q8);
      end
    end
  end

  // input side and run control
  initial begin
    setting_t s;
    bit       hit;
    window_t  res;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_quality  <= '0;
    in_read_end <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= swqm_pkg::CFG_WINDOW_SIZE;
    cfg_wdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_base(directed_rows[r].quality, directed_rows[r].read_end, hit, res);
      if (directed_rows[r].typed) begin
        if (directed_rows[r].emits) pending_windows.push_back(directed_rows[r].want);
      end else if (hit) begin
        pending_windows.push_back(res);
      end
    end

    foreach (phase_plan[p]) begin
      apply_setting(phase_plan[p]);
      run_reads(phase_plan[p].items, p == 0, p == 1);
    end

    repeat (4) begin
      s = '{1'b1, swqm_pkg::WSIZE_W'($urandom_range(2, 24)), 1'b1,
            swqm_pkg::WSTEP_W'($urandom_range(1, 6)), 16'd50, 1'b1};
      apply_setting(s);
      run_reads(50, 1'b0, 1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d bases in %0d reads over %0d register settings, short and clamped windows",
             bases_sent, track_reads, settings_applied);
    $display("%0d windows checked, %0d mismatches", windows_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
